[design/pfi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared types and constants of the palette fade interpolator.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int ChanW    = 8;              // width of one colour channel
  localparam int NumChan  = 3;              // red, green, blue
  localparam int ProdW    = 2 * ChanW;      // width of |diff| * step
  localparam int NumCells = ChanW;          // one quotient bit per divider cell

  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;

  typedef struct packed {
    logic [ChanW-1:0] entry_index;
    logic [ChanW-1:0] step;
    logic [ChanW-1:0] from_red;
    logic [ChanW-1:0] from_green;
    logic [ChanW-1:0] from_blue;
    logic [ChanW-1:0] to_red;
    logic [ChanW-1:0] to_green;
    logic [ChanW-1:0] to_blue;
  } fade_in_t;

  typedef struct packed {
    logic [ChanW-1:0] result_index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] luma;
    logic [ChanW-1:0] chroma_u;
    logic [ChanW-1:0] chroma_v;
  } fade_out_t;

  // item in flight through the divider chain
  typedef struct packed {
    logic [ChanW-1:0]              index;
    logic                          zero;  // step count of zero, take target
    logic [NumChan-1:0]            neg;   // target below source
    logic [NumChan-1:0][ChanW-1:0] from;
    logic [NumChan-1:0][ChanW-1:0] rem;   // partial remainder
    logic [NumChan-1:0][ChanW-1:0] low;   // dividend bits still to bring down
    logic [NumChan-1:0][ChanW-1:0] quo;   // quotient bits so far
  } div_t;

endpackage

[design/palette_fade_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_interpolator
// Blends palette entries between two colours and adds an approximate yuv.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid_i / in_ready_o carry one palette entry per beat
//     (index, fade step, source and target colour)
//   out channel: out_valid_o / out_ready_i carry one result beat per entry
//     (index, blended rgb, luma, chroma_u, chroma_v), in input order
//   cfg channel: cfg_valid_i / cfg_ready_o write fade_steps; always ready,
//     write it only while no entry is in flight
// timing
//   10 register stages: one stage for the products, eight divider cells
//   (one quotient bit each), one output register; one beat per cycle
//   sustained while out_ready_i stays high
//   every stage has its own valid bit and is ready when empty or when the
//   next stage is ready, so ready runs combinationally from the back; a
//   stalled receiver stalls the chain from the back and bubbles are
//   squeezed out; input is taken as long as the first stage can move
// reset
//   rst_ni clears all stage valid bits and sets fade_steps to 1
// ----------------------------------------------------------------------------
module palette_fade_interpolator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pfi_pkg::fade_in_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pfi_pkg::fade_out_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pfi_pkg::ChanW-1:0]   cfg_data_i
);
  import pfi_pkg::*;

  // fade step count, divisor of every cell
  logic [ChanW-1:0]    fade_steps_q;

  // stage k feeds cell k; stage NumCells feeds the output stage
  div_t                stage_data  [NumCells+1];
  logic [NumCells:0]   stage_valid;
  logic [NumCells:0]   stage_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_steps_q <= ChanW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      fade_steps_q <= cfg_data_i;
    end
  end

  // saturate step, form |to - from| * step per channel
  pfi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .steps_i     (fade_steps_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (stage_valid[0]),
    .out_ready_i (stage_ready[0]),
    .out_data_o  (stage_data[0])
  );

  // divider chain, msb of the quotient first
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    pfi_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .divisor_i   (fade_steps_q),
      .in_valid_i  (stage_valid[k]),
      .in_ready_o  (stage_ready[k]),
      .in_data_i   (stage_data[k]),
      .out_valid_o (stage_valid[k+1]),
      .out_ready_i (stage_ready[k+1]),
      .out_data_o  (stage_data[k+1])
    );
  end

  // apply signed quotient, yuv, output register
  pfi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid[NumCells]),
    .in_ready_o  (stage_ready[NumCells]),
    .in_data_i   (stage_data[NumCells]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // the division is done: every remainder sits below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid[NumCells] && (fade_steps_q != '0) |->
      (stage_data[NumCells].rem[ChRed] < fade_steps_q) &&
      (stage_data[NumCells].rem[ChGreen] < fade_steps_q) &&
      (stage_data[NumCells].rem[ChBlue] < fade_steps_q))
    else $error("divider remainder not below fade_steps");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.luma <= ChanW'(191)))
    else $error("luma out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.chroma_u >= ChanW'(64)) &&
                    (out_data_o.chroma_u <= ChanW'(191)))
    else $error("chroma_u out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.chroma_v >= ChanW'(64)) &&
                    (out_data_o.chroma_v <= ChanW'(191)))
    else $error("chroma_v out of range");
`endif

endmodule

[design/pfi_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_front
// Step saturation, channel differences and products; first pipeline stage.
// ----------------------------------------------------------------------------
module pfi_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pfi_pkg::ChanW-1:0]   steps_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pfi_pkg::fade_in_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pfi_pkg::div_t               out_data_o
);
  import pfi_pkg::*;

  logic [NumChan-1:0][ChanW-1:0] from_c;
  logic [NumChan-1:0][ChanW-1:0] to_c;
  logic [ChanW-1:0]              step_sat;
  logic [ChanW-1:0]              mag;
  logic [ProdW-1:0]              prod;
  logic                          zero;
  div_t                          data_d;
  div_t                          data_q;
  logic                          valid_q;

  assign from_c = {in_data_i.from_blue, in_data_i.from_green, in_data_i.from_red};
  assign to_c   = {in_data_i.to_blue, in_data_i.to_green, in_data_i.to_red};

  always_comb begin
    step_sat     = (in_data_i.step > steps_i) ? steps_i : in_data_i.step;
    zero         = (steps_i == '0);
    mag          = '0;
    prod         = '0;
    data_d       = '0;
    data_d.index = in_data_i.entry_index;
    data_d.zero  = zero;
    for (int ch = 0; ch < NumChan; ch++) begin
      data_d.neg[ch] = (to_c[ch] < from_c[ch]);
      mag            = data_d.neg[ch] ? (from_c[ch] - to_c[ch]) : (to_c[ch] - from_c[ch]);
      prod           = ProdW'(mag) * ProdW'(step_sat);
      // zero step count: blend collapses onto the target
      data_d.from[ch] = zero ? to_c[ch] : from_c[ch];
      data_d.rem[ch]  = prod[ProdW-1:ChanW];
      data_d.low[ch]  = prod[ChanW-1:0];
      data_d.quo[ch]  = '0;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

[design/pfi_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_div_cell
// One restoring division step for all three channels, registered.
// ----------------------------------------------------------------------------
module pfi_div_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pfi_pkg::ChanW-1:0]   divisor_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pfi_pkg::div_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pfi_pkg::div_t               out_data_o
);
  import pfi_pkg::*;

  logic [ChanW:0] trial;
  logic [ChanW:0] trial_sub;
  logic           ge;
  div_t           data_d;
  div_t           data_q;
  logic           valid_q;

  always_comb begin
    data_d    = in_data_i;
    trial     = '0;
    trial_sub = '0;
    ge        = 1'b0;
    for (int ch = 0; ch < NumChan; ch++) begin
      // bring down the next dividend bit
      trial     = {in_data_i.rem[ch], in_data_i.low[ch][ChanW-1]};
      trial_sub = trial - {1'b0, divisor_i};
      ge        = (trial >= {1'b0, divisor_i});
      data_d.rem[ch] = ge ? trial_sub[ChanW-1:0] : trial[ChanW-1:0];
      data_d.low[ch] = {in_data_i.low[ch][ChanW-2:0], 1'b0};
      data_d.quo[ch] = {in_data_i.quo[ch][ChanW-2:0], ge};
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

[design/pfi_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_back
// Applies the signed quotient, forms approximate yuv, output register.
// ----------------------------------------------------------------------------
module pfi_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pfi_pkg::div_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pfi_pkg::fade_out_t          out_data_o
);
  import pfi_pkg::*;

  localparam int SumW = ChanW + 2;
  localparam int VW   = ChanW + 3;
  localparam logic [ChanW-1:0] ChromaBase = ChanW'(64);
  localparam logic [SumW-1:0]  UBias      = SumW'(256);
  localparam logic [VW-1:0]    VBias      = VW'(512);

  logic [NumChan-1:0][ChanW-1:0] chan;
  logic [ChanW-1:0]              q;
  logic [SumW-1:0]               sum;
  logic [SumW-1:0]               u_t;
  logic [VW-1:0]                 v_t;
  fade_out_t                     data_d;
  fade_out_t                     data_q;
  logic                          valid_q;

  always_comb begin
    q = '0;
    for (int ch = 0; ch < NumChan; ch++) begin
      q        = in_data_i.zero ? '0 : in_data_i.quo[ch];
      chan[ch] = in_data_i.neg[ch] ? (in_data_i.from[ch] - q) : (in_data_i.from[ch] + q);
    end
    sum = SumW'(chan[ChRed]) + SumW'(chan[ChGreen]) + SumW'(chan[ChBlue]);
    u_t = SumW'(chan[ChRed]) + UBias - SumW'(chan[ChBlue]);
    v_t = VW'({chan[ChGreen], 1'b0}) + VBias - VW'(chan[ChRed]) - VW'(chan[ChBlue]);
    data_d.result_index = in_data_i.index;
    data_d.red          = chan[ChRed];
    data_d.green        = chan[ChGreen];
    data_d.blue         = chan[ChBlue];
    data_d.luma         = sum[SumW-1:2];
    data_d.chroma_u     = ChromaBase + u_t[SumW-1:2];
    data_d.chroma_v     = ChromaBase + v_t[VW-1:3];
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule
